// File: sv/debounced_two_level_alarm_monitor_macros.svh
// Assertion macros shared by the alarm monitor RTL.
// Every check is sampled on the rising edge of clk and is switched off while rst is high.
`ifndef DEBOUNCED_TWO_LEVEL_ALARM_MONITOR_MACROS_SVH
`define DEBOUNCED_TWO_LEVEL_ALARM_MONITOR_MACROS_SVH

// This condition must hold at every clock edge.
`define DTLAM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define DTLAM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define DTLAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dtlam_pkg.sv
// ----------------------------------------------------------------------------
// dtlam_pkg
// This package holds the types, widths and codes used by the alarm monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtlam_pkg;

  // There are five alarms, numbered in the order of their bits in the result masks.
  localparam int unsigned NUM_ALARMS    = 5;
  localparam int unsigned ALARM_T_HIGH  = 0;
  localparam int unsigned ALARM_T_LOW   = 1;
  localparam int unsigned ALARM_H_LOW   = 2;
  localparam int unsigned ALARM_C_HIGH  = 3;
  localparam int unsigned ALARM_C_LOW   = 4;

  // Widths of the payload fields.
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned HUM_W    = 14;
  localparam int unsigned CO2_W    = 14;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned COUNT_W  = 3;

  // Configuration port.
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // The debounce count after reset.
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd3;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_HIGH = 3'd0,
    REG_TEMP_LOW  = 3'd1,
    REG_HUM_LOW   = 3'd2,
    REG_CO2_HIGH  = 3'd3,
    REG_CO2_LOW   = 3'd4,
    REG_DEBOUNCE  = 3'd5
  } dtlam_reg_t;

  // Operation carried by an input word.
  typedef enum logic {
    MODE_SAMPLE  = 1'b0,
    MODE_ACK_ALL = 1'b1
  } dtlam_mode_t;

  // The zone a sample falls in for one alarm.
  typedef struct packed {
    logic beyond;   // past the warning or the critical limit
    logic crit;     // past the critical limit
  } dtlam_zone_t;

  // Control into one alarm lane.
  typedef struct packed {
    logic step;     // an input word is being processed this cycle
    logic ack_all;  // that word is an acknowledge-all command
  } dtlam_lane_ctrl_t;

  // The next state and the events of one alarm lane.
  typedef struct packed {
    logic active;
    logic critical;
    logic acked;
    logic raised;
    logic cleared;
  } dtlam_lane_status_t;

endpackage

`default_nettype wire

// File: sv/dtlam_sample_if.sv
// ----------------------------------------------------------------------------
// dtlam_sample_if
// This is the input channel. Each word carries one sample or an acknowledge-all command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dtlam_sample_if;
  import dtlam_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [TEMP_W-1:0] temperature;
  logic [HUM_W-1:0]         humidity;
  logic [CO2_W-1:0]         co2_level;

  modport source (output valid, mode, temperature, humidity, co2_level, input ready);
  modport sink   (input valid, mode, temperature, humidity, co2_level, output ready);
endinterface

`default_nettype wire

// File: sv/dtlam_result_if.sv
// ----------------------------------------------------------------------------
// dtlam_result_if
// This is the result channel. Each word carries the alarm state after one input word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dtlam_result_if;
  import dtlam_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [NUM_ALARMS-1:0] active_mask;
  logic [NUM_ALARMS-1:0] critical_mask;
  logic [NUM_ALARMS-1:0] acknowledged_mask;
  logic [NUM_ALARMS-1:0] raised_mask;
  logic [NUM_ALARMS-1:0] cleared_mask;
  logic [COUNT_W-1:0]    active_count;
  logic                  any_critical;

  modport source (output valid, active_mask, critical_mask, acknowledged_mask, raised_mask,
                  cleared_mask, active_count, any_critical, input ready);
  modport sink   (input valid, active_mask, critical_mask, acknowledged_mask, raised_mask,
                  cleared_mask, active_count, any_critical, output ready);
endinterface

`default_nettype wire

// File: sv/dtlam_alarm_lane.sv
// ----------------------------------------------------------------------------
// dtlam_alarm_lane
// This module holds the debounce counter and the active, severity and acknowledge
// flags of one alarm. It presents their next values and the raise and clear events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtlam_alarm_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dtlam_pkg::dtlam_lane_ctrl_t   ctrl,
  input  wire dtlam_pkg::dtlam_zone_t        zone,
  input  wire logic [dtlam_pkg::CNT_W-1:0]   debounce_limit,
  output dtlam_pkg::dtlam_lane_status_t      status
);
  import dtlam_pkg::*;

  logic [CNT_W-1:0] counter;
  logic [CNT_W-1:0] counter_next;
  logic [CNT_W-1:0] counter_inc;
  logic             active;
  logic             critical;
  logic             acked;

  // The counter saturates at the debounce count. A counter already above the count is held.
  assign counter_inc = (counter < debounce_limit) ? counter + 1'b1 : counter;

  // Work out the next lane state for the current word.
  always_comb begin
    counter_next   = counter;
    status.active   = active;
    status.critical = critical;
    status.acked    = acked;
    status.raised   = 1'b0;
    status.cleared  = 1'b0;
    if (ctrl.ack_all) begin
      status.acked = acked | active;
    end else if (zone.beyond) begin
      counter_next = counter_inc;
      if ((counter_inc >= debounce_limit) && !active) begin
        status.active   = 1'b1;
        status.acked    = 1'b0;
        status.critical = zone.crit;
        status.raised   = 1'b1;
      end
    end else begin
      counter_next = '0;
      if (active) begin
        status.active   = 1'b0;
        status.critical = 1'b0;
        status.acked    = 1'b0;
        status.cleared  = 1'b1;
      end
    end
  end

  // Commit the new state when a word is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter  <= '0;
      active   <= 1'b0;
      critical <= 1'b0;
      acked    <= 1'b0;
    end else if (ctrl.step) begin
      counter  <= counter_next;
      active   <= status.active;
      critical <= status.critical;
      acked    <= status.acked;
    end
  end

endmodule

`default_nettype wire

// File: sv/debounced_two_level_alarm_monitor.sv
// ----------------------------------------------------------------------------
// debounced_two_level_alarm_monitor
// This block checks temperature, humidity and CO2 samples against critical and warning
// limits, debounces each alarm and reports the alarm state.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle unless the result register is full and is not
// being taken; each word is either a sample or an acknowledge-all command. Every word gives
// exactly one result word. A word first lands in an input register. It then passes through
// the limit comparisons and the five alarm lanes into the result register, and the alarm
// state is committed in the same cycle. The output register takes a new result whenever it
// is empty or its word is being taken, so both sides can stream without gaps. The limit and
// debounce registers may only be written while no word is inside the block.
`timescale 1ns / 1ps
`default_nettype none

module debounced_two_level_alarm_monitor (
  input  wire logic                               clk,
  input  wire logic                               rst,
  dtlam_sample_if.sink                            sample,
  dtlam_result_if.source                          result,
  input  wire logic                               cfg_write_en,
  input  wire logic [dtlam_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dtlam_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dtlam_pkg::*;

`include "debounced_two_level_alarm_monitor_macros.svh"

  // Configuration registers.
  logic [CFG_DATA_W-1:0] temp_high_limits;
  logic [CFG_DATA_W-1:0] temp_low_limits;
  logic [CFG_DATA_W-1:0] humidity_low_limits;
  logic [CFG_DATA_W-1:0] co2_high_limits;
  logic [CFG_DATA_W-1:0] co2_low_limits;
  logic [CNT_W-1:0]      debounce_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_high_limits    <= '0;
      temp_low_limits     <= '0;
      humidity_low_limits <= '0;
      co2_high_limits     <= '0;
      co2_low_limits      <= '0;
      debounce_limit      <= DEBOUNCE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_TEMP_HIGH: temp_high_limits    <= cfg_data;
        REG_TEMP_LOW:  temp_low_limits     <= cfg_data;
        REG_HUM_LOW:   humidity_low_limits <= cfg_data;
        REG_CO2_HIGH:  co2_high_limits     <= cfg_data;
        REG_CO2_LOW:   co2_low_limits      <= cfg_data;
        REG_DEBOUNCE:  debounce_limit      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The input register advances when it is empty or the result register can load.
  logic s1_valid;
  logic s1_fire;
  logic out_can_load;

  assign out_can_load = !result.valid || result.ready;
  assign s1_fire      = s1_valid && out_can_load;
  assign sample.ready = !s1_valid || s1_fire;

  // Input register.
  logic                     s1_mode;
  logic signed [TEMP_W-1:0] s1_temperature;
  logic [HUM_W-1:0]         s1_humidity;
  logic [CO2_W-1:0]         s1_co2_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_mode        <= sample.mode;
      s1_temperature <= sample.temperature;
      s1_humidity    <= sample.humidity;
      s1_co2_level   <= sample.co2_level;
    end
  end

  // Limit comparisons. Temperature limits are signed, the others unsigned.
  logic [LIMIT_W-1:0]      hum_ext;
  logic [LIMIT_W-1:0]      co2_ext;
  dtlam_zone_t             zone [NUM_ALARMS];

  assign hum_ext = {{(LIMIT_W-HUM_W){1'b0}}, s1_humidity};
  assign co2_ext = {{(LIMIT_W-CO2_W){1'b0}}, s1_co2_level};

  always_comb begin
    zone[ALARM_T_HIGH].crit =
      s1_temperature > $signed(temp_high_limits[CFG_DATA_W-1:LIMIT_W]);
    zone[ALARM_T_HIGH].beyond = zone[ALARM_T_HIGH].crit ||
      (s1_temperature > $signed(temp_high_limits[LIMIT_W-1:0]));

    zone[ALARM_T_LOW].crit =
      s1_temperature < $signed(temp_low_limits[CFG_DATA_W-1:LIMIT_W]);
    zone[ALARM_T_LOW].beyond = zone[ALARM_T_LOW].crit ||
      (s1_temperature < $signed(temp_low_limits[LIMIT_W-1:0]));

    zone[ALARM_H_LOW].crit   = hum_ext < humidity_low_limits[CFG_DATA_W-1:LIMIT_W];
    zone[ALARM_H_LOW].beyond = zone[ALARM_H_LOW].crit ||
      (hum_ext < humidity_low_limits[LIMIT_W-1:0]);

    zone[ALARM_C_HIGH].crit   = co2_ext > co2_high_limits[CFG_DATA_W-1:LIMIT_W];
    zone[ALARM_C_HIGH].beyond = zone[ALARM_C_HIGH].crit ||
      (co2_ext > co2_high_limits[LIMIT_W-1:0]);

    zone[ALARM_C_LOW].crit   = co2_ext < co2_low_limits[CFG_DATA_W-1:LIMIT_W];
    zone[ALARM_C_LOW].beyond = zone[ALARM_C_LOW].crit ||
      (co2_ext < co2_low_limits[LIMIT_W-1:0]);
  end

  // The alarm lanes.
  dtlam_lane_ctrl_t   lane_ctrl;
  dtlam_lane_status_t lane_status [NUM_ALARMS];

  assign lane_ctrl.step    = s1_fire;
  assign lane_ctrl.ack_all = (s1_mode == MODE_ACK_ALL);

  for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_lane
    dtlam_alarm_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (lane_ctrl),
      .zone           (zone[i]),
      .debounce_limit (debounce_limit),
      .status         (lane_status[i])
    );
  end

  // Gather the lane states into the result masks.
  logic [NUM_ALARMS-1:0] active_next;
  logic [NUM_ALARMS-1:0] crit_next;
  logic [NUM_ALARMS-1:0] ack_next;
  logic [NUM_ALARMS-1:0] raised_next;
  logic [NUM_ALARMS-1:0] cleared_next;
  logic [COUNT_W-1:0]    count_next;

  always_comb begin
    count_next = '0;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      active_next[i]  = lane_status[i].active;
      crit_next[i]    = lane_status[i].critical & lane_status[i].active;
      ack_next[i]     = lane_status[i].acked & lane_status[i].active;
      raised_next[i]  = lane_status[i].raised;
      cleared_next[i] = lane_status[i].cleared;
      count_next      = count_next + {{(COUNT_W-1){1'b0}}, lane_status[i].active};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_can_load) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result.active_mask       <= active_next;
      result.critical_mask     <= crit_next;
      result.acknowledged_mask <= ack_next;
      result.raised_mask       <= raised_next;
      result.cleared_mask      <= cleared_next;
      result.active_count      <= count_next;
      result.any_critical      <= |crit_next;
    end
  end

  // Checks on the result word and on the acknowledge path.
  `DTLAM_ASSERT_IMPLIES(a_crit_in_active, result.valid, (result.critical_mask & ~result.active_mask) == '0, "critical alarm is not active")
  `DTLAM_ASSERT_IMPLIES(a_events_consistent, result.valid, ((result.raised_mask & ~result.active_mask) == '0) && ((result.cleared_mask & result.active_mask) == '0), "raise or clear event disagrees with the active mask")
  `DTLAM_ASSERT_IMPLIES(a_count_matches, result.valid, (result.active_count == COUNT_W'($countones(result.active_mask))) && (result.any_critical == (result.critical_mask != '0)), "active count or any_critical is inconsistent")
  `DTLAM_ASSERT_NEXT(a_ack_all_result, s1_fire && (s1_mode == MODE_ACK_ALL), (result.acknowledged_mask == result.active_mask) && (result.raised_mask == '0) && (result.cleared_mask == '0), "acknowledge-all word gave a wrong result")

endmodule

`default_nettype wire

// File: tb/sv/tb_debounced_two_level_alarm_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_two_level_alarm_monitor
// Self-checking bench for the debounced alarm monitor. A short table of words
// covers reset values, field and limit extremes, acknowledge-all, severity
// hold, critical limits inside warning limits and the debounce corner cases.
// Random limit settings then follow, driven by sticky samples that seek the
// limits so that alarms are raised and cleared. Each result word is compared
// with an in-bench model of the five alarm lanes.
// ----------------------------------------------------------------------------
module tb_debounced_two_level_alarm_monitor;
  import dtlam_pkg::*;

  typedef enum logic [1:0] {ZONE_OK, ZONE_WARN, ZONE_CRIT} zone_t;

  typedef struct packed {
    logic [NUM_ALARMS-1:0] active;
    logic [NUM_ALARMS-1:0] crit;
    logic [NUM_ALARMS-1:0] acked;
    logic [NUM_ALARMS-1:0] raised;
    logic [NUM_ALARMS-1:0] cleared;
    logic [COUNT_W-1:0]    count;
    logic                  any_crit;
  } alarm_report_t;

  typedef struct {
    logic                     is_write;
    dtlam_reg_t               wr_index;
    logic [CFG_DATA_W-1:0]    wr_data;
    dtlam_mode_t              mode;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
    logic [CO2_W-1:0]         co2;
    logic                     typed;
    alarm_report_t            want;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dtlam_sample_if sample_ch ();
  dtlam_result_if result_ch ();

  debounced_two_level_alarm_monitor u_top (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample_ch),
    .result       (result_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the limit registers and the alarm lanes.
  logic [CFG_DATA_W-1:0] lim_reg [5];
  logic [CNT_W-1:0]      debounce_len;
  logic [CNT_W-1:0]      lane_count [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] alarm_on;
  logic [NUM_ALARMS-1:0] alarm_crit;
  logic [NUM_ALARMS-1:0] alarm_ack;

  alarm_report_t report_q [$];
  table_row_t    rows [$];
  int fault_count = 0;
  int words_sample = 0;
  int words_ack = 0;
  int write_total = 0;
  int raise_total = 0;
  int clear_total = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  int sink_hold = 0;

  function automatic zone_t zone_above(int x, int crit, int warn);
    if (x > crit) return ZONE_CRIT;
    if (x > warn) return ZONE_WARN;
    return ZONE_OK;
  endfunction

  function automatic zone_t zone_below(int x, int crit, int warn);
    if (x < crit) return ZONE_CRIT;
    if (x < warn) return ZONE_WARN;
    return ZONE_OK;
  endfunction

  // One lane: count while beyond a limit, raise once the count is reached,
  // and drop everything as soon as the sample is back in range.
  function automatic void update_lane(int i, zone_t z,
                                      inout logic [NUM_ALARMS-1:0] raised,
                                      inout logic [NUM_ALARMS-1:0] cleared);
    if (z != ZONE_OK) begin
      if (lane_count[i] < debounce_len) lane_count[i] = lane_count[i] + 1'b1;
      if (lane_count[i] >= debounce_len && !alarm_on[i]) begin
        alarm_on[i]   = 1'b1;
        alarm_ack[i]  = 1'b0;
        alarm_crit[i] = (z == ZONE_CRIT);
        raised[i]     = 1'b1;
      end
    end else begin
      lane_count[i] = '0;
      if (alarm_on[i]) begin
        alarm_on[i]   = 1'b0;
        alarm_crit[i] = 1'b0;
        alarm_ack[i]  = 1'b0;
        cleared[i]    = 1'b1;
      end
    end
  endfunction

  // Advances the shadow alarm state by one word and returns its result word.
  function automatic alarm_report_t apply_word(dtlam_mode_t mode, logic signed [TEMP_W-1:0] t,
                                               logic [HUM_W-1:0] h, logic [CO2_W-1:0] c);
    logic [NUM_ALARMS-1:0] raised;
    logic [NUM_ALARMS-1:0] cleared;
    alarm_report_t r;
    int tv, hv, cv;
    int th_c, th_w, tl_c, tl_w, hl_c, hl_w, ch_c, ch_w, cl_c, cl_w;
    raised  = '0;
    cleared = '0;
    if (mode == MODE_ACK_ALL) begin
      alarm_ack = alarm_ack | alarm_on;
    end else begin
      tv = t;
      hv = h;
      cv = c;
      // Temperature limits are signed, humidity and CO2 limits unsigned.
      th_c = $signed(lim_reg[REG_TEMP_HIGH][31:16]);
      th_w = $signed(lim_reg[REG_TEMP_HIGH][15:0]);
      tl_c = $signed(lim_reg[REG_TEMP_LOW][31:16]);
      tl_w = $signed(lim_reg[REG_TEMP_LOW][15:0]);
      hl_c = lim_reg[REG_HUM_LOW][31:16];
      hl_w = lim_reg[REG_HUM_LOW][15:0];
      ch_c = lim_reg[REG_CO2_HIGH][31:16];
      ch_w = lim_reg[REG_CO2_HIGH][15:0];
      cl_c = lim_reg[REG_CO2_LOW][31:16];
      cl_w = lim_reg[REG_CO2_LOW][15:0];
      update_lane(ALARM_T_HIGH, zone_above(tv, th_c, th_w), raised, cleared);
      update_lane(ALARM_T_LOW, zone_below(tv, tl_c, tl_w), raised, cleared);
      update_lane(ALARM_H_LOW, zone_below(hv, hl_c, hl_w), raised, cleared);
      update_lane(ALARM_C_HIGH, zone_above(cv, ch_c, ch_w), raised, cleared);
      update_lane(ALARM_C_LOW, zone_below(cv, cl_c, cl_w), raised, cleared);
    end
    r.active   = alarm_on;
    r.crit     = alarm_crit & alarm_on;
    r.acked    = alarm_ack & alarm_on;
    r.raised   = raised;
    r.cleared  = cleared;
    r.count    = COUNT_W'($countones(alarm_on));
    r.any_crit = |(alarm_crit & alarm_on);
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Limit pair for one register: mostly in the working range, sometimes extreme.
  // The order of the halves is random, so the critical limit often sits inside.
  function automatic logic [CFG_DATA_W-1:0] rand_limits(bit is_temp);
    logic [LIMIT_W-1:0] a, b;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {16'h7FFF, 16'h8000};
      3: return {16'h8000, 16'h7FFF};
      default: begin
        if (is_temp) begin
          a = 16'($urandom_range(0, 8000) - 4000);
          b = 16'($urandom_range(0, 8000) - 4000);
        end else begin
          a = 16'($urandom_range(0, 10000));
          b = 16'($urandom_range(0, 10000));
        end
        return {a, b};
      end
    endcase
  endfunction

  // A value just either side of one of the limits of the given registers.
  function automatic logic [LIMIT_W-1:0] near_limit(dtlam_reg_t first, int n_regs);
    int k;
    logic [CFG_DATA_W-1:0] pair;
    k = $urandom_range(0, 2 * n_regs - 1);
    pair = lim_reg[int'(first) + k / 2];
    return (k % 2 ? pair[31:16] : pair[15:0]) + 16'($urandom_range(0, 6)) - 16'd3;
  endfunction

  function automatic table_row_t item_row(dtlam_mode_t mode, logic signed [TEMP_W-1:0] t,
                                          logic [HUM_W-1:0] h, logic [CO2_W-1:0] c);
    table_row_t row;
    row.is_write = 1'b0;
    row.wr_index = REG_TEMP_HIGH;
    row.wr_data  = '0;
    row.mode     = mode;
    row.temp     = t;
    row.hum      = h;
    row.co2      = c;
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic table_row_t checked_row(dtlam_mode_t mode, logic signed [TEMP_W-1:0] t,
                                             logic [HUM_W-1:0] h, logic [CO2_W-1:0] c,
                                             alarm_report_t want);
    table_row_t row;
    row       = item_row(mode, t, h, c);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic table_row_t cfg_row(dtlam_reg_t idx, logic [CFG_DATA_W-1:0] d);
    table_row_t row;
    row          = item_row(MODE_SAMPLE, '0, '0, '0);
    row.is_write = 1'b1;
    row.wr_index = idx;
    row.wr_data  = d;
    return row;
  endfunction

  // Appends one row to the stimulus table.
  function automatic void add_row(table_row_t row);
    rows = {rows, row};
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("Mismatch on %s at %0t ns: expected %0d, got %0d", what, $time, want, got);
    end
  endfunction

  // Offers one word after a random gap and records its expected result once taken.
  task automatic send_word(dtlam_mode_t mode, logic signed [TEMP_W-1:0] t,
                           logic [HUM_W-1:0] h, logic [CO2_W-1:0] c,
                           logic typed, alarm_report_t want);
    int gap;
    alarm_report_t predicted;
    alarm_report_t expected;
    cfg_write_en <= 1'b0;
    if ($urandom_range(0, 99) < 2) src_calm = !src_calm;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.mode        <= mode;
    sample_ch.temperature <= t;
    sample_ch.humidity    <= h;
    sample_ch.co2_level   <= c;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = apply_word(mode, t, h, c);
    expected  = typed ? want : predicted;
    report_q  = {report_q, expected};
    if (mode == MODE_ACK_ALL) words_ack++;
    else words_sample++;
    raise_total += $countones(predicted.raised);
    clear_total += $countones(predicted.cleared);
  endtask

  // Registers change only with the block empty.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(dtlam_reg_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= d;
    @(posedge clk);
    if (idx == REG_DEBOUNCE) debounce_len = d[CNT_W-1:0];
    else lim_reg[idx] = d;
    write_total++;
  endtask

  // Result side: check every word taken, then stall at random.
  always @(posedge clk) begin
    alarm_report_t got;
    alarm_report_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.active   = result_ch.active_mask;
        got.crit     = result_ch.critical_mask;
        got.acked    = result_ch.acknowledged_mask;
        got.raised   = result_ch.raised_mask;
        got.cleared  = result_ch.cleared_mask;
        got.count    = result_ch.active_count;
        got.any_crit = result_ch.any_critical;
        if (report_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("Unexpected result word at %0t ns", $time);
        end else begin
          want = report_q.pop_front();
          check_field("active_mask", want.active, got.active);
          check_field("critical_mask", want.crit, got.crit);
          check_field("acknowledged_mask", want.acked, got.acked);
          check_field("raised_mask", want.raised, got.raised);
          check_field("cleared_mask", want.cleared, got.cleared);
          check_field("active_count", want.count, got.count);
          check_field("any_critical", want.any_crit, got.any_crit);
        end
      end
      if (sink_hold > 0) begin
        sink_hold = sink_hold - 1;
        result_ch.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 2) sink_calm = !sink_calm;
        sink_hold = pick_gap(sink_calm);
        if (sink_hold > 0) begin
          sink_hold = sink_hold - 1;
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic signed [TEMP_W-1:0] cur_t;
    logic [HUM_W-1:0]         cur_h;
    logic [CO2_W-1:0]         cur_c;
    logic [LIMIT_W-1:0]       near;
    int n_items;
    int t_hold;
    int ph;
    int i;

    sample_ch.valid       <= 1'b0;
    sample_ch.mode        <= MODE_SAMPLE;
    sample_ch.temperature <= '0;
    sample_ch.humidity    <= '0;
    sample_ch.co2_level   <= '0;
    cfg_write_en          <= 1'b0;
    cfg_index             <= REG_TEMP_HIGH;
    cfg_data              <= '0;

    for (i = 0; i < 5; i++) lim_reg[i] = '0;
    for (i = 0; i < NUM_ALARMS; i++) lane_count[i] = '0;
    debounce_len = DEBOUNCE_RESET;
    alarm_on     = '0;
    alarm_crit   = '0;
    alarm_ack    = '0;

    // Directed words. With every limit at zero a zero sample is beyond no limit.
    add_row(checked_row(MODE_ACK_ALL, 16'sd0, 14'd0, 14'd0, '0));
    add_row(checked_row(MODE_SAMPLE, 16'sd0, 14'd0, 14'd0, '0));
    add_row(item_row(MODE_SAMPLE, 16'sd1, 14'd0, 14'd1));
    // Fast debounce and ordinary limits.
    add_row(cfg_row(REG_DEBOUNCE, 32'd1));
    add_row(cfg_row(REG_TEMP_HIGH, {16'd3000, 16'd2500}));
    add_row(cfg_row(REG_TEMP_LOW, {-16'sd1000, 16'sd0}));
    add_row(cfg_row(REG_HUM_LOW, {16'd2000, 16'd3000}));
    add_row(cfg_row(REG_CO2_HIGH, {16'd8000, 16'd5000}));
    add_row(cfg_row(REG_CO2_LOW, {16'd100, 16'd200}));
    add_row(checked_row(MODE_SAMPLE, 16'sh7FFF, 14'd0, 14'd10000,
                        '{5'b01101, 5'b01101, 5'b00000, 5'b01101, 5'b00000, 3'd3, 1'b1}));
    add_row(checked_row(MODE_ACK_ALL, 16'sd0, 14'd0, 14'd0,
                        '{5'b01101, 5'b01101, 5'b01101, 5'b00000, 5'b00000, 3'd3, 1'b1}));
    // Humidity above its nominal range is compared as it stands.
    add_row(checked_row(MODE_SAMPLE, 16'sh8000, 14'h3FFF, 14'd0,
                        '{5'b10010, 5'b10010, 5'b00000, 5'b10010, 5'b01101, 3'd2, 1'b1}));
    // Warning-zone raises; an alarm already active keeps its severity.
    add_row(item_row(MODE_SAMPLE, 16'sd2600, 14'd2500, 14'd150));
    add_row(item_row(MODE_SAMPLE, 16'sh7FFF, 14'd2500, 14'd150));
    add_row(item_row(MODE_ACK_ALL, 16'sh1234, 14'h2AAA, 14'h1555));
    // Critical limits inside the warning limits.
    add_row(cfg_row(REG_TEMP_HIGH, {16'd1000, 16'd2000}));
    add_row(cfg_row(REG_HUM_LOW, {16'd5000, 16'd3000}));
    add_row(item_row(MODE_SAMPLE, 16'sd0, 14'd9000, 14'd500));
    add_row(item_row(MODE_SAMPLE, 16'sd1500, 14'd4000, 14'd500));
    add_row(item_row(MODE_SAMPLE, 16'sd0, 14'd9000, 14'd500));
    add_row(item_row(MODE_SAMPLE, 16'sd2500, 14'd2000, 14'd500));
    // Slow debounce, then lowered below a running count.
    add_row(cfg_row(REG_DEBOUNCE, 32'd10));
    add_row(item_row(MODE_SAMPLE, 16'sd0, 14'd9000, 14'd500));
    for (i = 0; i < 4; i++) add_row(item_row(MODE_SAMPLE, 16'sd0, 14'd9000, 14'd9000));
    add_row(cfg_row(REG_DEBOUNCE, 32'd2));
    add_row(item_row(MODE_SAMPLE, 16'sd0, 14'd9000, 14'd9000));
    // A debounce count of zero raises at once.
    add_row(cfg_row(REG_DEBOUNCE, 32'd0));
    add_row(item_row(MODE_SAMPLE, -16'sd2000, 14'd9000, 14'd500));
    // Extreme limits and the longest debounce.
    add_row(cfg_row(REG_TEMP_HIGH, 32'h7FFF_7FFF));
    add_row(cfg_row(REG_TEMP_LOW, 32'h8000_8000));
    add_row(cfg_row(REG_HUM_LOW, 32'hFFFF_FFFF));
    add_row(cfg_row(REG_CO2_HIGH, 32'hFFFF_FFFF));
    add_row(cfg_row(REG_CO2_LOW, 32'h0000_0000));
    add_row(cfg_row(REG_DEBOUNCE, 32'd255));
    add_row(item_row(MODE_SAMPLE, 16'sh7FFF, 14'h3FFF, 14'h3FFF));
    add_row(item_row(MODE_SAMPLE, 16'sh8000, 14'd0, 14'd0));
    add_row(cfg_row(REG_CO2_HIGH, 32'h0000_0000));
    add_row(item_row(MODE_SAMPLE, 16'sd0, 14'd0, 14'h3FFF));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      if (rows[k].is_write) begin
        settle();
        write_reg(rows[k].wr_index, rows[k].wr_data);
      end else begin
        send_word(rows[k].mode, rows[k].temp, rows[k].hum, rows[k].co2,
                  rows[k].typed, rows[k].want);
      end
    end

    // Random phases. The first holds the temperature still under the longest
    // debounce so that a count of 255 is actually reached.
    cur_t = '0;
    cur_h = '0;
    cur_c = '0;
    for (ph = 0; ph < 8; ph++) begin
      n_items = (ph == 0) ? 300 : 45;
      settle();
      write_reg(REG_TEMP_HIGH, rand_limits(1'b1));
      write_reg(REG_TEMP_LOW, rand_limits(1'b1));
      write_reg(REG_HUM_LOW, rand_limits(1'b0));
      write_reg(REG_CO2_HIGH, rand_limits(1'b0));
      write_reg(REG_CO2_LOW, rand_limits(1'b0));
      write_reg(REG_DEBOUNCE, (ph == 0) ? 32'd255 :
                              (ph == 1) ? 32'd1 : 32'($urandom_range(1, 6)));
      if (ph == 0) cur_t = 16'sh7FFF;
      t_hold = (ph == 0) ? 1000 : 900;
      for (i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          send_word(MODE_ACK_ALL, 16'($urandom), 14'($urandom), 14'($urandom), 1'b0, '0);
        end else begin
          // Each field mostly keeps its value so that runs build up the counts.
          if ($urandom_range(0, 999) >= t_hold) begin
            if ($urandom_range(0, 1)) cur_t = near_limit(REG_TEMP_HIGH, 2);
            else cur_t = 16'($urandom);
          end
          if ($urandom_range(0, 999) >= 900) begin
            near = near_limit(REG_HUM_LOW, 1);
            case ($urandom_range(0, 2))
              0: cur_h = near[HUM_W-1:0];
              1: cur_h = 14'($urandom_range(0, 10000));
              default: cur_h = 14'($urandom);
            endcase
          end
          if ($urandom_range(0, 999) >= 900) begin
            near = near_limit(REG_CO2_HIGH, 2);
            case ($urandom_range(0, 2))
              0: cur_c = near[CO2_W-1:0];
              1: cur_c = 14'($urandom_range(0, 10000));
              default: cur_c = 14'($urandom);
            endcase
          end
          send_word(MODE_SAMPLE, cur_t, cur_h, cur_c, 1'b0, '0);
        end
      end
    end

    sample_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d sample words and %0d acknowledge words with %0d register writes.",
             words_sample, words_ack, write_total);
    $display("Alarm raises seen: %0d, clears seen: %0d, field mismatches: %0d.",
             raise_total, clear_total, fault_count);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
